// File: design/s2fc_pkg.sv
// ----------------------------------------------------------------------------
// s2fc_pkg
// Shared register indexes and color map codes of the false color mapper.
// ----------------------------------------------------------------------------
package s2fc_pkg;

    localparam int MODE_BITS  = 2;
    localparam int INDEX_BITS = 2;

    // register indexes on the configuration port
    localparam logic [INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_MAP_MODE   = 2'd2;

    // color map codes
    localparam logic [MODE_BITS-1:0] MODE_JET  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_GRAY = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BLUE_RED = 2'd2;

    typedef logic [MODE_BITS-1:0] map_mode_t;

endpackage

// File: design/scalar_to_false_color.sv
// ----------------------------------------------------------------------------
// scalar_to_false_color
// Normalizes a signed sample against a programmed range and maps it to RGB.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the skid buffer is empty and returns one
// RGB item per sample, in order. The stages are one input register, range
// subtract, overflow check, a restoring divider that resolves one quotient
// bit per stage over FRAC_BITS + 2 stages, saturation, the color map, and
// the channel scaling multipliers. A one-entry skid buffer after the last
// stage holds a result that the sink does not take, so the pipe keeps
// running until that buffer is full. Program range_low, range_high and
// map_mode only while no item is in flight; the map reads them live.
// ----------------------------------------------------------------------------
module scalar_to_false_color
    import s2fc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COLOR_BITS  = 8,
    parameter int FRAC_BITS   = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [INDEX_BITS-1:0]         cfg_index,
    input  logic [SAMPLE_BITS-1:0]        cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COLOR_BITS-1:0]         red,
    output logic [COLOR_BITS-1:0]         green,
    output logic [COLOR_BITS-1:0]         blue
);

    localparam int DW  = SAMPLE_BITS + 1;            // difference width
    localparam int QB  = FRAC_BITS + 2;              // quotient bits kept
    localparam int RW  = SAMPLE_BITS + FRAC_BITS + 4; // remainder width
    localparam int TW  = FRAC_BITS + 3;              // normalized value width
    localparam int MW  = FRAC_BITS + 7;              // map arithmetic width
    localparam int UW  = FRAC_BITS + 1;              // clamped channel width
    localparam int PW  = UW + COLOR_BITS + 1;        // scaling product width
    localparam int NS  = QB + 6;

    localparam logic [QB-1:0] Q_LOW  = QB'(1) << (FRAC_BITS - 2);
    localparam logic [QB-1:0] Q_HIGH = QB'(5) << (FRAC_BITS - 2);
    localparam logic signed [TW-1:0] T_LOW  = -(TW'(1) << (FRAC_BITS - 2));
    localparam logic signed [TW-1:0] T_HIGH = TW'(5) << (FRAC_BITS - 2);
    localparam logic signed [MW-1:0] ONE_W  = MW'(1) << FRAC_BITS;
    localparam logic signed [MW-1:0] HALF_W = MW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] COLOR_MAX = PW'((1 << COLOR_BITS) - 1);
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (FRAC_BITS - 1);

    // configuration registers
    logic signed [SAMPLE_BITS-1:0] range_low_reg;
    logic signed [SAMPLE_BITS-1:0] range_high_reg;
    map_mode_t                     map_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= SAMPLE_BITS'(32767);
            map_mode_reg   <= MODE_JET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                REG_RANGE_HIGH: range_high_reg <= cfg_data;
                REG_MAP_MODE:   map_mode_reg   <= map_mode_t'(cfg_data[MODE_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // pipeline control: every stage moves while the skid buffer is empty
    logic [NS-1:0] valid_reg;
    logic          skid_valid_reg;
    logic          advance;

    assign advance  = !skid_valid_reg;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    // stage 0: input register
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg <= sample;
        end
    end

    // stage 1: magnitudes of numerator and divisor
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] span;
    logic [DW-1:0]        diff_mag;
    logic [DW-1:0]        span_mag;
    logic [RW-1:0]        num_reg;
    logic [DW-1:0]        den_s1_reg;
    logic                 neg_s1_reg;
    logic                 zero_s1_reg;

    always_comb
    begin
        diff     = {sample_reg[SAMPLE_BITS-1], sample_reg}
                 - {range_low_reg[SAMPLE_BITS-1], range_low_reg};
        span     = {range_high_reg[SAMPLE_BITS-1], range_high_reg}
                 - {range_low_reg[SAMPLE_BITS-1], range_low_reg};
        diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
        span_mag = span[DW-1] ? DW'(-span) : DW'(span);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg     <= RW'({diff_mag, {FRAC_BITS{1'b0}}});
            den_s1_reg  <= span_mag;
            neg_s1_reg  <= diff[DW-1] ^ span[DW-1];
            zero_s1_reg <= (span == '0);
        end
    end

    // stage 2 (index 0) and divider stages (index 1..QB)
    logic [RW-1:0] rem_reg  [0:QB];
    logic [QB-1:0] quo_reg  [0:QB];
    logic [DW-1:0] den_reg  [0:QB];
    logic          neg_reg  [0:QB];
    logic          zero_reg [0:QB];
    logic          ovf_reg  [0:QB];

    logic [RW-1:0] rem_next [1:QB];
    logic [QB-1:0] quo_next [1:QB];

    always_comb
    begin
        for (int d = 1; d <= QB; d++)
        begin
            rem_next[d] = rem_reg[d-1];
            quo_next[d] = quo_reg[d-1];
            // try the divisor at weight 2^(QB-d)
            if (rem_reg[d-1] >= (RW'(den_reg[d-1]) << (QB - d)))
            begin
                rem_next[d]          = rem_reg[d-1] - (RW'(den_reg[d-1]) << (QB - d));
                quo_next[d][QB - d]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= num_reg;
            quo_reg[0]  <= '0;
            den_reg[0]  <= den_s1_reg;
            neg_reg[0]  <= neg_s1_reg;
            zero_reg[0] <= zero_s1_reg;
            // quotient beyond the kept bits saturates anyway
            ovf_reg[0]  <= (num_reg >= (RW'(den_s1_reg) << QB));
            for (int d = 1; d <= QB; d++)
            begin
                rem_reg[d]  <= rem_next[d];
                quo_reg[d]  <= quo_next[d];
                den_reg[d]  <= den_reg[d-1];
                neg_reg[d]  <= neg_reg[d-1];
                zero_reg[d] <= zero_reg[d-1];
                ovf_reg[d]  <= ovf_reg[d-1];
            end
        end
    end

    // saturation stage: signed normalized value in [-0.25, 1.25]
    logic signed [TW-1:0] t_next;
    logic signed [TW-1:0] t_reg;

    always_comb
    begin
        if (zero_reg[QB])
        begin
            t_next = '0;
        end
        else if (neg_reg[QB])
        begin
            if (ovf_reg[QB] || (quo_reg[QB] > Q_LOW))
                t_next = T_LOW;
            else
                t_next = -$signed(TW'(quo_reg[QB]));
        end
        else
        begin
            if (ovf_reg[QB] || (quo_reg[QB] > Q_HIGH))
                t_next = T_HIGH;
            else
                t_next = $signed(TW'(quo_reg[QB]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_reg <= t_next;
        end
    end

    // map stage
    function automatic logic [UW-1:0] clamp_unit(input logic signed [MW-1:0] v);
        if (v < 0)
            return '0;
        else if (v > ONE_W)
            return UW'(ONE_W);
        else
            return UW'(v);
    endfunction

    logic signed [MW-1:0] t_w;
    logic signed [MW-1:0] t4;
    logic signed [MW-1:0] t10;
    logic signed [MW-1:0] r_w;
    logic signed [MW-1:0] g_w;
    logic signed [MW-1:0] b_w;
    logic [UW-1:0]        r_reg;
    logic [UW-1:0]        g_reg;
    logic [UW-1:0]        b_reg;

    always_comb
    begin
        t_w = MW'(t_reg);
        t4  = t_w <<< 2;
        t10 = (t_w <<< 3) + (t_w <<< 1);
        r_w = '0;
        g_w = '0;
        b_w = '0;
        case (map_mode_reg)
            MODE_JET:
            begin
                if (t10 < MW'(7) * ONE_W)
                    r_w = t4 - MW'(3) * HALF_W;
                else
                    r_w = MW'(9) * HALF_W - t4;
                if ((t_w <<< 1) < ONE_W)
                    g_w = t4 - HALF_W;
                else
                    g_w = MW'(7) * HALF_W - t4;
                if (t10 < MW'(3) * ONE_W)
                    b_w = t4 + HALF_W;
                else
                    b_w = MW'(5) * HALF_W - t4;
            end
            MODE_GRAY:
            begin
                r_w = t_w;
                g_w = t_w;
                b_w = t_w;
            end
            MODE_BLUE_RED:
            begin
                if ((t_w <<< 1) < ONE_W)
                begin
                    r_w = t_w <<< 1;
                    g_w = t_w <<< 1;
                    b_w = ONE_W;
                end
                else
                begin
                    r_w = ONE_W;
                    g_w = (ONE_W - t_w) <<< 1;
                    b_w = (ONE_W - t_w) <<< 1;
                end
            end
            default:
            begin
                r_w = '0;
                g_w = '0;
                b_w = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_reg <= clamp_unit(r_w);
            g_reg <= clamp_unit(g_w);
            b_reg <= clamp_unit(b_w);
        end
    end

    // scaling stage: round(v * (2^COLOR_BITS - 1))
    logic [PW-1:0]         r_prod;
    logic [PW-1:0]         g_prod;
    logic [PW-1:0]         b_prod;
    logic [COLOR_BITS-1:0] red_reg;
    logic [COLOR_BITS-1:0] green_reg;
    logic [COLOR_BITS-1:0] blue_reg;

    always_comb
    begin
        r_prod = PW'(r_reg) * COLOR_MAX + ROUND_HALF;
        g_prod = PW'(g_reg) * COLOR_MAX + ROUND_HALF;
        b_prod = PW'(b_reg) * COLOR_MAX + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= r_prod[FRAC_BITS +: COLOR_BITS];
            green_reg <= g_prod[FRAC_BITS +: COLOR_BITS];
            blue_reg  <= b_prod[FRAC_BITS +: COLOR_BITS];
        end
    end

    // skid buffer: park the last item when the sink stalls
    logic                  skid_valid_next;
    logic [COLOR_BITS-1:0] skid_red_reg;
    logic [COLOR_BITS-1:0] skid_green_reg;
    logic [COLOR_BITS-1:0] skid_blue_reg;

    always_comb
    begin
        if (skid_valid_reg)
            skid_valid_next = !out_ready;
        else
            skid_valid_next = valid_reg[NS-1] && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_red_reg   <= red_reg;
            skid_green_reg <= green_reg;
            skid_blue_reg  <= blue_reg;
        end
    end

    assign out_valid = skid_valid_reg || valid_reg[NS-1];
    assign red       = skid_valid_reg ? skid_red_reg   : red_reg;
    assign green     = skid_valid_reg ? skid_green_reg : green_reg;
    assign blue      = skid_valid_reg ? skid_blue_reg  : blue_reg;

endmodule

// File: dv/tb_scalar_to_false_color.sv
// ----------------------------------------------------------------------------
// tb_scalar_to_false_color
// Self-checking bench for the scalar to false color mapper.
// ----------------------------------------------------------------------------
// Drives signed samples through a valid/ready source with random bursts and
// gaps and takes RGB items through a sink that stalls on its own pattern.
// A behavioral copy of the mapping (range normalization, saturation, jet,
// gray and blue-to-red maps, channel rounding) predicts every item, and the
// checker compares red, green and blue in order. Registers are reprogrammed
// only once the pipe has drained.
// ----------------------------------------------------------------------------
module tb_scalar_to_false_color;
    import s2fc_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int COLOR_BITS  = 8;
    localparam int FRAC_BITS   = 12;

    localparam int     PIPE_LATENCY = FRAC_BITS + 8;
    localparam longint FX_ONE       = longint'(1) << FRAC_BITS;
    localparam longint FX_HALF      = longint'(1) << (FRAC_BITS - 1);
    localparam longint COLOR_MAX    = (longint'(1) << COLOR_BITS) - 1;

    // the package has no name for the spare map code
    localparam map_mode_t MODE_UNUSED = 2'd3;

    localparam int RANDOM_PHASES    = 16;
    localparam int ITEMS_PER_PHASE  = 100;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [COLOR_BITS-1:0]         red;
        logic [COLOR_BITS-1:0]         green;
        logic [COLOR_BITS-1:0]         blue;
    } rgb_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [INDEX_BITS-1:0]         cfg_index;
    logic [SAMPLE_BITS-1:0]        cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          out_valid;
    logic                          out_ready;
    logic [COLOR_BITS-1:0]         red;
    logic [COLOR_BITS-1:0]         green;
    logic [COLOR_BITS-1:0]         blue;

    // mirror of the programmed registers
    logic signed [SAMPLE_BITS-1:0] cur_low;
    logic signed [SAMPLE_BITS-1:0] cur_high;
    map_mode_t                     cur_mode;

    rgb_t pending_rgb[$];
    int   burst_left;
    int   hold_cycles;
    int   n_items;
    int   n_checked;
    int   n_errors;
    int   n_phases;

    scalar_to_false_color #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COLOR_BITS  (COLOR_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [COLOR_BITS-1:0] to_channel(input longint v);
        longint u;
        u = (v < 0) ? 0 : ((v > FX_ONE) ? FX_ONE : v);
        return COLOR_BITS'((u * COLOR_MAX + FX_HALF) >>> FRAC_BITS);
    endfunction

    function automatic rgb_t map_to_rgb(input logic signed [SAMPLE_BITS-1:0] s);
        longint lo;
        longint hi;
        longint den;
        longint t;
        longint r;
        longint g;
        longint b;
        rgb_t   c;
        lo  = cur_low;
        hi  = cur_high;
        den = hi - lo;
        t   = 0;
        if (den != 0)
            t = ((longint'(s) - lo) * FX_ONE) / den;
        if (t < -(FX_ONE / 4))
            t = -(FX_ONE / 4);
        if (t > 5 * (FX_ONE / 4))
            t = 5 * (FX_ONE / 4);
        case (cur_mode)
            MODE_JET:
            begin
                r = (10 * t < 7 * FX_ONE) ? 4 * t - 3 * FX_HALF : -4 * t + 9 * FX_HALF;
                g = (2 * t < FX_ONE)      ? 4 * t - FX_HALF     : -4 * t + 7 * FX_HALF;
                b = (10 * t < 3 * FX_ONE) ? 4 * t + FX_HALF     : -4 * t + 5 * FX_HALF;
            end
            MODE_GRAY:
            begin
                r = t;
                g = t;
                b = t;
            end
            MODE_BLUE_RED:
            begin
                if (2 * t < FX_ONE)
                begin
                    r = 2 * t;
                    g = 2 * t;
                    b = FX_ONE;
                end
                else
                begin
                    r = FX_ONE;
                    g = 2 * (FX_ONE - t);
                    b = 2 * (FX_ONE - t);
                end
            end
            default:
            begin
                r = 0;
                g = 0;
                b = 0;
            end
        endcase
        c.sample = s;
        c.red    = to_channel(r);
        c.green  = to_channel(g);
        c.blue   = to_channel(b);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // sink: stall pattern plus requested hold-offs
    // ------------------------------------------------------------------
    initial
    begin : sink_stall
        int style;
        int style_left;
        int cyc;
        style      = 0;
        style_left = 0;
        cyc        = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((cyc % 7) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rgb_t exp_rgb;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rgb.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected item r/g/b %0d/%0d/%0d", $time, red, green, blue);
            end
            else
            begin
                exp_rgb = pending_rgb.pop_front();
                n_checked++;
                if (red !== exp_rgb.red || green !== exp_rgb.green || blue !== exp_rgb.blue)
                begin
                    n_errors++;
                    $display("%0t: sample %0d expected r/g/b %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, exp_rgb.sample, exp_rgb.red, exp_rgb.green,
                             exp_rgb.blue, red, green, blue);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_rgb.push_back(map_to_rgb(s));
        n_items++;
    endtask

    // hold the source until every item has come back, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_RANGE_LOW:  cur_low  = data;
            REG_RANGE_HIGH: cur_high = data;
            REG_MAP_MODE:   cur_mode = map_mode_t'(data);
            default:        ;
        endcase
    endtask

    task automatic program_map(input int lo, input int hi, input map_mode_t mode);
        wait_drained();
        write_reg(REG_RANGE_LOW, SAMPLE_BITS'(lo));
        write_reg(REG_RANGE_HIGH, SAMPLE_BITS'(hi));
        write_reg(REG_MAP_MODE, SAMPLE_BITS'(mode));
        n_phases++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        int pts[4] = '{-32768, 0, 16384, 32767};
        foreach (pts[i])
            send_sample(SAMPLE_BITS'(pts[i]));
    endtask

    // a 0..4096 range makes t equal to the sample, so breakpoints land exactly
    task automatic test_jet_breakpoints();
        int pts[13] = '{-32768, -1025, -1024, 0, 1228, 1229, 2047, 2048,
                        2867, 2868, 4096, 5120, 32767};
        program_map(0, 4096, MODE_JET);
        foreach (pts[i])
            send_sample(SAMPLE_BITS'(pts[i]));
    endtask

    task automatic test_gray_and_blue_red();
        program_map(0, 4096, MODE_GRAY);
        send_sample(-1);
        send_sample(4097);
        program_map(0, 4096, MODE_BLUE_RED);
        send_sample(2047);
        send_sample(2048);
    endtask

    task automatic test_special_ranges();
        // empty range, reversed range, then the spare map code
        program_map(100, 100, MODE_BLUE_RED);
        send_sample(12345);
        program_map(4096, 0, MODE_JET);
        send_sample(1024);
        program_map(-32768, 32767, MODE_UNUSED);
        send_sample(SAMPLE_BITS'($urandom));
    endtask

    task automatic test_random_phases();
        int        lo;
        int        hi;
        int        a;
        int        b;
        int        margin;
        int        v;
        map_mode_t mode;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       begin lo = -32768; hi = 32767;  end
                1:       begin lo = 32767;  hi = -32768; end
                2:       begin lo = -32768; hi = -32768; end
                3:       begin lo = $urandom_range(0, 60000) - 32768; hi = lo + $urandom_range(1, 64); end
                default:
                begin
                    lo = $signed(SAMPLE_BITS'($urandom));
                    hi = $signed(SAMPLE_BITS'($urandom));
                end
            endcase
            if (hi > 32767)
                hi = 32767;
            mode = (p == 5) ? MODE_UNUSED : map_mode_t'($urandom_range(0, 2));
            program_map(lo, hi, mode);
            a      = (lo < hi) ? lo : hi;
            b      = (lo < hi) ? hi : lo;
            margin = (b - a) / 4;
            a      = (a - margin < -32768) ? -32768 : a - margin;
            b      = (b + margin > 32767) ? 32767 : b + margin;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // mostly inside the programmed span widened by a quarter on each side, so every ramp gets exercised
                if ($urandom_range(0, 4) != 0)
                    v = a + int'($urandom_range(0, b - a));
                else
                    v = $signed(SAMPLE_BITS'($urandom));
                send_sample(SAMPLE_BITS'(v));
            end
        end
    endtask

    // sink holds off long enough for the pipe and skid buffer to fill
    task automatic test_backpressure();
        program_map(-4000, 4000, MODE_JET);
        @(negedge clk);
        hold_cycles = 4 * PIPE_LATENCY + 20;
        burst_left  = 80;
        for (int i = 0; i < 80; i++)
            send_sample(SAMPLE_BITS'($urandom_range(0, 9000) - 4500));
        wait_drained();
        for (int i = 0; i < 30; i++)
            send_sample(SAMPLE_BITS'($urandom));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample      = '0;
        burst_left  = 0;
        hold_cycles = 0;
        n_items     = 0;
        n_checked   = 0;
        n_errors    = 0;
        n_phases    = 1;
        cur_low     = 0;
        cur_high    = 32767;
        cur_mode    = MODE_JET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_jet_breakpoints();
        test_gray_and_blue_red();
        test_special_ranges();
        test_random_phases();
        test_backpressure();
        wait_drained();

        if (pending_rgb.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d items never came out", $time, pending_rgb.size());
        end
        $display("Run covered %0d samples over %0d register settings: all map codes,",
                 n_items, n_phases);
        $display("empty, reversed and full-scale ranges, sink hold-off; %0d checked, %0d bad",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
